>>> hw/rtl/icle_pkg.sv
// Shared types and constants for the indexed circular list engine.
package icle_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ACT_W      = 4;
    localparam int POS_W      = 7;
    localparam int ELEM_W     = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);

    // Request codes carried in the action field.
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_FIRST = 4'd0,
        ACT_ADD_LAST  = 4'd1,
        ACT_INSERT    = 4'd2,
        ACT_GET_FIRST = 4'd3,
        ACT_GET_LAST  = 4'd4,
        ACT_GET       = 4'd5,
        ACT_SET       = 4'd6,
        ACT_RM_FIRST  = 4'd7,
        ACT_RM_LAST   = 4'd8,
        ACT_RM        = 4'd9,
        ACT_ROT_FWD   = 4'd10,
        ACT_ROT_BACK  = 4'd11,
        ACT_CLEAR     = 4'd12
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS,
        OP_RMV,
        OP_SET,
        OP_ROTF,
        OP_ROTB
    } cell_op_t;

    // Row control: idx is the insert, remove or set slot, or the last slot
    // for rotations; rd_idx selects the slot whose value is read out.
    typedef struct packed {
        cell_op_t                op;
        logic [CNT_W-1:0]        idx;
        logic [CNT_W-1:0]        rd_idx;
        logic [DATA_WIDTH-1:0]   element;
    } row_ctrl_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ELEM_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
        logic              list_empty;
    } rsp_t;

endpackage

>>> hw/rtl/icle_cell.sv
// One storage cell of the list row: holds one element and shifts with its neighbors.
module icle_cell (
    input  logic                               clk,
    input  logic [icle_pkg::IDX_W-1:0]         my_idx,
    input  icle_pkg::row_ctrl_t                ctrl,
    input  logic [icle_pkg::DATA_WIDTH-1:0]    left_data,
    input  logic [icle_pkg::DATA_WIDTH-1:0]    right_data,
    input  logic [icle_pkg::DATA_WIDTH-1:0]    wrap_data,
    output logic [icle_pkg::DATA_WIDTH-1:0]    data,
    output logic [icle_pkg::DATA_WIDTH-1:0]    hit_data
);

    logic [icle_pkg::DATA_WIDTH-1:0] value_reg;
    logic [icle_pkg::DATA_WIDTH-1:0] value_next;
    logic [icle_pkg::CNT_W-1:0]      pos;
    logic                            at_idx;
    logic                            above_idx;

    assign pos       = icle_pkg::CNT_W'(my_idx);
    assign at_idx    = (pos == ctrl.idx);
    assign above_idx = (pos > ctrl.idx);

    // Select the next value from this cell, a neighbor or the new element.
    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            icle_pkg::OP_INS:
            begin
                if (above_idx)
                    value_next = left_data;
                else if (at_idx)
                    value_next = ctrl.element;
            end
            icle_pkg::OP_RMV:
            begin
                if (above_idx || at_idx)
                    value_next = right_data;
            end
            icle_pkg::OP_SET:
            begin
                if (at_idx)
                    value_next = ctrl.element;
            end
            icle_pkg::OP_ROTF:
            begin
                if (at_idx)
                    value_next = wrap_data;
                else if (!above_idx)
                    value_next = right_data;
            end
            icle_pkg::OP_ROTB:
            begin
                if (my_idx == '0)
                    value_next = wrap_data;
                else if (!above_idx)
                    value_next = left_data;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Element storage, no reset needed for payload.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign data     = value_reg;
    assign hit_data = (pos == ctrl.rd_idx) ? value_reg : '0;

endmodule

>>> hw/rtl/icle_row.sv
// Row of list cells with neighbor links, rotation wrap path and read-out selection.
module icle_row (
    input  logic                             clk,
    input  icle_pkg::row_ctrl_t              ctrl,
    output logic [icle_pkg::DATA_WIDTH-1:0]  rd_data
);

    logic [icle_pkg::DATA_WIDTH-1:0] cell_data [icle_pkg::DEPTH];
    logic [icle_pkg::DATA_WIDTH-1:0] cell_hit  [icle_pkg::DEPTH];
    logic [icle_pkg::DATA_WIDTH-1:0] wrap_data;

    // The first element wraps to the end on a forward rotation; the last
    // element, picked by the read selection, wraps to the front otherwise.
    assign wrap_data = (ctrl.op == icle_pkg::OP_ROTF) ? cell_data[0] : rd_data;

    // Cells with links to both neighbors; the row ends see zero.
    for (genvar i = 0; i < icle_pkg::DEPTH; i++)
    begin : g_cell
        logic [icle_pkg::DATA_WIDTH-1:0] left_d;
        logic [icle_pkg::DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == icle_pkg::DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        icle_cell u_cell (
            .clk        (clk),
            .my_idx     (icle_pkg::IDX_W'(i)),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .wrap_data  (wrap_data),
            .data       (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // At most one cell matches the read index, so an OR merges the row.
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < icle_pkg::DEPTH; i++)
        begin
            rd_data = rd_data | cell_hit[i];
        end
    end

endmodule

>>> hw/rtl/indexed_circular_list_engine.sv
// Top level: request decode, element count and registered result for the list engine.
//
//  Channel | Signals                       | Item
//  --------+-------------------------------+------------------------------------
//  request | in_valid, in_ready, in_item   | action, position, element
//  result  | out_valid, out_ready, out_item| status, read_value, count, list_empty
//
// One item is accepted per cycle while the output register is free; its result
// appears in the output register on the next cycle. Every shift, insert, remove
// or rotate moves all affected cells of the row at once, so the clock period is
// set by the row update and the read-out selection across the cells. Reset clears
// the count and the result valid flag; cell contents are not cleared. A new item is
// taken whenever the output register is empty or being drained in the same cycle.
module indexed_circular_list_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  icle_pkg::req_t   in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output icle_pkg::rsp_t   out_item
);

    logic                             out_valid_reg;
    logic                             out_valid_next;
    icle_pkg::rsp_t                   out_reg;
    icle_pkg::rsp_t                   out_next;
    logic [icle_pkg::CNT_W-1:0]       count_reg;
    logic [icle_pkg::CNT_W-1:0]       count_next;
    logic                             in_fire;
    icle_pkg::row_ctrl_t              ctrl;
    icle_pkg::status_t                status;
    logic                             ret_value;
    logic [icle_pkg::DATA_WIDTH-1:0]  rd_data;
    logic [icle_pkg::CNT_W-1:0]       pos;
    logic [icle_pkg::CNT_W-1:0]       last;
    logic                             full;
    logic                             empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign pos   = icle_pkg::CNT_W'(in_item.position);
    assign last  = count_reg - icle_pkg::CNT_W'(1);
    assign full  = (count_reg == icle_pkg::CNT_W'(icle_pkg::DEPTH));
    assign empty = (count_reg == '0);

    // Request decode: status, row operation and the new count.
    always_comb
    begin
        ctrl.op      = icle_pkg::OP_HOLD;
        ctrl.idx     = '0;
        ctrl.rd_idx  = '0;
        ctrl.element = icle_pkg::DATA_WIDTH'(in_item.element);
        status       = icle_pkg::ST_OK;
        ret_value    = 1'b0;
        count_next   = count_reg;
        unique case (icle_pkg::action_t'(in_item.action))
            icle_pkg::ACT_ADD_FIRST,
            icle_pkg::ACT_ADD_LAST:
            begin
                if (full)
                    status = icle_pkg::ST_FULL;
                else
                begin
                    ctrl.op    = icle_pkg::OP_INS;
                    ctrl.idx   = (in_item.action == icle_pkg::ACT_ADD_FIRST) ? '0 : count_reg;
                    count_next = count_reg + icle_pkg::CNT_W'(1);
                end
            end
            icle_pkg::ACT_INSERT:
            begin
                if (pos > count_reg)
                    status = icle_pkg::ST_BAD_INDEX;
                else if (full)
                    status = icle_pkg::ST_FULL;
                else
                begin
                    ctrl.op    = icle_pkg::OP_INS;
                    ctrl.idx   = pos;
                    count_next = count_reg + icle_pkg::CNT_W'(1);
                end
            end
            icle_pkg::ACT_GET_FIRST,
            icle_pkg::ACT_GET_LAST:
            begin
                if (empty)
                    status = icle_pkg::ST_EMPTY;
                else
                begin
                    ret_value   = 1'b1;
                    ctrl.rd_idx = (in_item.action == icle_pkg::ACT_GET_FIRST) ? '0 : last;
                end
            end
            icle_pkg::ACT_RM_FIRST,
            icle_pkg::ACT_RM_LAST:
            begin
                if (empty)
                    status = icle_pkg::ST_EMPTY;
                else
                begin
                    ret_value   = 1'b1;
                    ctrl.op     = icle_pkg::OP_RMV;
                    ctrl.idx    = (in_item.action == icle_pkg::ACT_RM_FIRST) ? '0 : last;
                    ctrl.rd_idx = ctrl.idx;
                    count_next  = last;
                end
            end
            icle_pkg::ACT_GET,
            icle_pkg::ACT_SET,
            icle_pkg::ACT_RM:
            begin
                if (empty)
                    status = icle_pkg::ST_EMPTY;
                else if (pos >= count_reg)
                    status = icle_pkg::ST_BAD_INDEX;
                else
                begin
                    ret_value   = 1'b1;
                    ctrl.idx    = pos;
                    ctrl.rd_idx = pos;
                    if (in_item.action == icle_pkg::ACT_SET)
                        ctrl.op = icle_pkg::OP_SET;
                    else if (in_item.action == icle_pkg::ACT_RM)
                    begin
                        ctrl.op    = icle_pkg::OP_RMV;
                        count_next = last;
                    end
                end
            end
            icle_pkg::ACT_ROT_FWD,
            icle_pkg::ACT_ROT_BACK:
            begin
                if (count_reg > icle_pkg::CNT_W'(1))
                begin
                    ctrl.op     = (in_item.action == icle_pkg::ACT_ROT_FWD) ?
                                  icle_pkg::OP_ROTF : icle_pkg::OP_ROTB;
                    ctrl.idx    = last;
                    ctrl.rd_idx = last;
                end
            end
            icle_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = icle_pkg::ST_OK;
            end
        endcase
        // Without an accepted item the row holds.
        if (!in_fire)
            ctrl.op = icle_pkg::OP_HOLD;
    end

    icle_row u_row (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_data (rd_data)
    );

    // Result assembly for the output register.
    always_comb
    begin
        out_next.status     = status;
        out_next.read_value = ret_value ? icle_pkg::ELEM_W'(rd_data) : '0;
        out_next.count      = count_next;
        out_next.list_empty = (count_next == '0);
        out_valid_next      = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state: count and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
                count_reg <= count_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The count never exceeds the row length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= icle_pkg::CNT_W'(icle_pkg::DEPTH))
        else $error("element count beyond depth");

    // An accepted item always leaves a result behind.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted item produced no result");

    // A pending result reports the current count and its empty flag.
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.count == count_reg &&
                           out_reg.list_empty == (count_reg == '0)))
        else $error("result count disagrees with state");

    // A failed request returns a zero value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != icle_pkg::ST_OK) |-> out_reg.read_value == '0)
        else $error("failed request returned a value");

endmodule

>>> dv/list_result_checker.sv
// Checker for the indexed circular list engine: predicts every result and compares it.
`timescale 1ns / 1ps

module list_result_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  icle_pkg::req_t in_item,
    input  logic           out_valid,
    input  logic           out_ready,
    input  icle_pkg::rsp_t out_item,
    output int             fail_count,
    output int             pending_results
);

    // Shadow of the ring in logical order: entry 0 is the first element.
    logic [icle_pkg::DATA_WIDTH-1:0] slot_data [icle_pkg::DEPTH];
    int                              list_count;
    int                              mismatch_count;
    icle_pkg::rsp_t                  expected_results [$];

    // Applies one request to the shadow ring and returns the result it must produce.
    function automatic icle_pkg::rsp_t apply_list_request(input icle_pkg::req_t req);
        icle_pkg::rsp_t                  res;
        int                              at;
        int                              i;
        logic [icle_pkg::DATA_WIDTH-1:0] carry;
        res.status     = icle_pkg::ST_OK;
        res.read_value = '0;
        at             = int'(req.position);
        case (req.action)
            icle_pkg::ACT_ADD_FIRST, icle_pkg::ACT_ADD_LAST, icle_pkg::ACT_INSERT:
            begin
                if (req.action == icle_pkg::ACT_ADD_FIRST)
                    at = 0;
                else if (req.action == icle_pkg::ACT_ADD_LAST)
                    at = list_count;
                // The index is judged before fullness; an index equal to the count appends.
                if (at > list_count)
                    res.status = icle_pkg::ST_BAD_INDEX;
                else if (list_count >= icle_pkg::DEPTH)
                    res.status = icle_pkg::ST_FULL;
                else
                begin
                    for (i = list_count; i > at; i--)
                        slot_data[i] = slot_data[i-1];
                    slot_data[at] = req.element;
                    list_count++;
                end
            end
            icle_pkg::ACT_GET_FIRST, icle_pkg::ACT_GET_LAST, icle_pkg::ACT_GET,
            icle_pkg::ACT_SET, icle_pkg::ACT_RM_FIRST, icle_pkg::ACT_RM_LAST,
            icle_pkg::ACT_RM:
            begin
                if (req.action == icle_pkg::ACT_GET_FIRST ||
                    req.action == icle_pkg::ACT_RM_FIRST)
                    at = 0;
                else if (req.action == icle_pkg::ACT_GET_LAST ||
                         req.action == icle_pkg::ACT_RM_LAST)
                    at = list_count - 1;
                // An empty list wins over a bad index.
                if (list_count == 0)
                    res.status = icle_pkg::ST_EMPTY;
                else if (at >= list_count)
                    res.status = icle_pkg::ST_BAD_INDEX;
                else
                begin
                    res.read_value = slot_data[at];
                    if (req.action == icle_pkg::ACT_SET)
                        slot_data[at] = req.element;
                    else if (req.action == icle_pkg::ACT_RM_FIRST ||
                             req.action == icle_pkg::ACT_RM_LAST ||
                             req.action == icle_pkg::ACT_RM)
                    begin
                        for (i = at; i < list_count - 1; i++)
                            slot_data[i] = slot_data[i+1];
                        list_count--;
                    end
                end
            end
            icle_pkg::ACT_ROT_FWD:
            begin
                if (list_count > 1)
                begin
                    carry = slot_data[0];
                    for (i = 0; i < list_count - 1; i++)
                        slot_data[i] = slot_data[i+1];
                    slot_data[list_count-1] = carry;
                end
            end
            icle_pkg::ACT_ROT_BACK:
            begin
                if (list_count > 1)
                begin
                    carry = slot_data[list_count-1];
                    for (i = list_count - 1; i > 0; i--)
                        slot_data[i] = slot_data[i-1];
                    slot_data[0] = carry;
                end
            end
            icle_pkg::ACT_CLEAR:
                list_count = 0;
            default:
                ;
        endcase
        res.count      = icle_pkg::CNT_W'(list_count);
        res.list_empty = (list_count == 0);
        return res;
    endfunction

    // Counts a field mismatch; only the first ten are reported in detail.
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: result field %s mismatch: expected %0h, got %0h",
                         $realtime, field, want, got);
        end
    endtask

    // Results are checked before the new item is predicted; both follow arrival order.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        icle_pkg::rsp_t want;
        if (!rst_n)
        begin
            list_count = 0;
            mismatch_count = 0;
            expected_results.delete();
            fail_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result item with no request outstanding", $realtime);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(out_item.status));
                    check_field("read_value", want.read_value, out_item.read_value);
                    check_field("count", 32'(want.count), 32'(out_item.count));
                    check_field("list_empty", 32'(want.list_empty),
                                32'(out_item.list_empty));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_list_request(in_item));
            fail_count <= mismatch_count;
            pending_results <= expected_results.size();
        end
    end

endmodule

>>> dv/tb_indexed_circular_list_engine.sv
// Top of the list engine testbench: clock, reset, request stimulus, result backpressure, verdict.
`timescale 1ns / 1ps

module tb_indexed_circular_list_engine;

    // Action codes that the block does not define; they must change nothing.
    localparam logic [icle_pkg::ACT_W-1:0] ACT_RESERVED_FIRST = 4'd13;
    localparam logic [icle_pkg::ACT_W-1:0] ACT_RESERVED_LAST  = 4'd15;

    localparam int RANDOM_ITEMS = 1325;
    localparam int PHASE_ITEMS  = 120;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 300;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } traffic_mode_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    icle_pkg::req_t in_item;
    logic           out_valid;
    logic           out_ready;
    icle_pkg::rsp_t out_item;
    logic           no_idle = 1'b0;
    int             fail_count;
    int             pending_results;

    always #4 clk = ~clk;

    indexed_circular_list_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    list_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_item        (out_item),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Offers one request item, with random idle cycles ahead of it unless no_idle is set, and waits until taken.
    task automatic send_request(input logic [icle_pkg::ACT_W-1:0]  act,
                                input logic [icle_pkg::POS_W-1:0]  pos,
                                input logic [icle_pkg::ELEM_W-1:0] elem);
        icle_pkg::req_t req;
        req.action   = act;
        req.position = pos;
        req.element  = elem;
        while (!no_idle && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Result side: random stalls, one long hold-off that backs the block up, then a busy stretch.
    initial
    begin : result_sink
        int cycle;
        cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
                out_ready <= 1'b0;
            else if (no_idle)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    // Request stimulus and verdict.
    initial
    begin : stimulus
        traffic_mode_t                   mode;
        int                              n;
        int                              pick;
        logic [icle_pkg::ACT_W-1:0]      act;
        logic [icle_pkg::POS_W-1:0]      pos;
        logic [icle_pkg::ELEM_W-1:0]     elem;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases, starting from an empty list.
        send_request(icle_pkg::ACT_GET_FIRST, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_RM, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_SET, 7'd0, 32'h1111_1111);
        send_request(icle_pkg::ACT_ROT_FWD, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_ROT_BACK, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_INSERT, 7'd1, 32'h2222_2222);
        send_request(icle_pkg::ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_request(icle_pkg::ACT_RM_LAST, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_ADD_LAST, 7'd0, 32'h0000_0000);
        send_request(icle_pkg::ACT_ADD_FIRST, 7'd0, 32'hFFFF_FFFF);
        send_request(icle_pkg::ACT_INSERT, 7'd2, 32'hA5A5_A5A5);
        send_request(icle_pkg::ACT_INSERT, 7'd127, 32'h5A5A_5A5A);
        send_request(icle_pkg::ACT_GET, 7'd3, 32'h0);
        send_request(icle_pkg::ACT_GET, 7'd1, 32'h0);
        send_request(icle_pkg::ACT_SET, 7'd0, 32'h1234_5678);
        send_request(icle_pkg::ACT_GET_FIRST, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_GET_LAST, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_ROT_FWD, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_ROT_BACK, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_RM, 7'd1, 32'h0);
        send_request(icle_pkg::ACT_RM_FIRST, 7'd0, 32'h0);
        send_request(ACT_RESERVED_FIRST, 7'd64, 32'hDEAD_BEEF);
        send_request(ACT_RESERVED_LAST, 7'd127, 32'hFFFF_FFFF);
        send_request(icle_pkg::ACT_CLEAR, 7'd0, 32'h0);
        send_request(icle_pkg::ACT_GET_LAST, 7'd0, 32'h0);

        // Random traffic in a repeating pattern of phases: two growing phases fill the ring
        // past full, two shrinking phases drain it past empty, then a mixed phase.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / PHASE_ITEMS) % 5)
                0, 1:    mode = MODE_GROW;
                2, 3:    mode = MODE_SHRINK;
                default: mode = MODE_MIXED;
            endcase
            no_idle = (n >= 500 && n < 700);

            pick = $urandom_range(0, 99);
            if (mode == MODE_GROW)
            begin
                if (pick < 70)
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_ADD_FIRST,
                                                          icle_pkg::ACT_INSERT));
                else if (pick < 85)
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_GET_FIRST,
                                                          icle_pkg::ACT_SET));
                else if (pick < 95)
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_ROT_FWD,
                                                          icle_pkg::ACT_ROT_BACK));
                else
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_RM_FIRST,
                                                          icle_pkg::ACT_RM));
            end
            else if (mode == MODE_SHRINK)
            begin
                if (pick < 65)
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_RM_FIRST,
                                                          icle_pkg::ACT_RM));
                else if (pick < 80)
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_GET_FIRST,
                                                          icle_pkg::ACT_SET));
                else if (pick < 90)
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_ADD_FIRST,
                                                          icle_pkg::ACT_INSERT));
                else if (pick < 97)
                    act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_ROT_FWD,
                                                          icle_pkg::ACT_ROT_BACK));
                else if (pick < 99)
                    act = icle_pkg::ACT_CLEAR;
                else
                    act = icle_pkg::ACT_W'($urandom_range(ACT_RESERVED_FIRST,
                                                          ACT_RESERVED_LAST));
            end
            else
                act = icle_pkg::ACT_W'($urandom_range(icle_pkg::ACT_ADD_FIRST,
                                                      ACT_RESERVED_LAST));

            // Positions lean toward small indexes but reach every 7-bit value.
            pick = $urandom_range(0, 99);
            if (pick < 85)
                pos = icle_pkg::POS_W'($urandom_range(0, $urandom_range(0, icle_pkg::DEPTH)));
            else
                pos = icle_pkg::POS_W'($urandom_range(0, 127));

            pick = $urandom_range(0, 99);
            if (pick < 10)
                elem = '0;
            else if (pick < 20)
                elem = '1;
            else
                elem = $urandom;

            send_request(act, pos, elem);
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        // Drain every outstanding result, then let the block sit quiet before the verdict.
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/icle_pkg.sv
hw/rtl/icle_cell.sv
hw/rtl/icle_row.sv
hw/rtl/indexed_circular_list_engine.sv
dv/list_result_checker.sv
dv/tb_indexed_circular_list_engine.sv
